[rtl/rtwp_pkg.sv]
// rtwp_pkg: types, constants and word tables for the remaining-time word phrase block
// no dependencies; imported by every other file in rtl/

package rtwp_pkg;

  localparam int unsigned SECS_W = 32;
  localparam int unsigned LOW_W  = 16;
  localparam int unsigned HOUR_W = 4;
  localparam int unsigned REM_W  = 12;
  localparam int unsigned FIVE_W = 13;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned MASK_W = 25;
  localparam int unsigned BG_W   = 2;

  localparam logic [LOW_W-1:0]  SECS_PER_HOUR = 16'd3600;
  localparam logic [FIVE_W-1:0] SECS_PER_FIVE = 13'd300;
  localparam logic [FIVE_W-1:0] HALF_ROUND    = 13'd120;
  localparam logic [HOUR_W-1:0] MAX_HOURS     = 4'd12;
  localparam logic [IDX_W-1:0]  FULL_HOUR_IDX = 4'd12;
  // 12 h 58 min and above rounds past twelve hours
  localparam logic [SECS_W-1:0] SAT_SECS      = 32'd46680;

  localparam int unsigned W_MORE   = 0;
  localparam int unsigned W_LESS   = 1;
  localparam int unsigned W_THAN   = 2;
  localparam int unsigned W_HEAT   = 14;
  localparam int unsigned W_TWELVE = 15;
  localparam int unsigned W_ERROR  = 16;
  localparam int unsigned W_TWENTY = 17;
  localparam int unsigned W_TEN    = 18;
  localparam int unsigned W_THIRTY = 19;
  localparam int unsigned W_FORTY  = 20;
  localparam int unsigned W_TAIL5  = 21;
  localparam int unsigned W_FIFTY  = 22;
  localparam int unsigned W_LEFT   = 23;
  localparam int unsigned W_DONE   = 24;
  localparam int unsigned W_FIVE   = 7;

  typedef enum logic [2:0] {
    ST_UNAVAIL,
    ST_IDLE,
    ST_HEATING,
    ST_ERROR,
    ST_DONE,
    ST_PAUSED,
    ST_RESUMING,
    ST_PRINTING
  } print_state_t;

  typedef enum logic [BG_W-1:0] {
    BG_OFF,
    BG_IDLE,
    BG_PAUSE
  } bg_t;

  typedef struct packed {
    print_state_t            state;
    logic                    sat;
    logic [HOUR_W-1:0]       hours;
    logic [REM_W-1:0]        rem;
  } split_t;

  function automatic logic [LOW_W-1:0] hour_base(input logic [HOUR_W-1:0] h);
    hour_base = LOW_W'(h) * SECS_PER_HOUR;
  endfunction

  function automatic logic [FIVE_W-1:0] five_base(input logic [IDX_W-1:0] k);
    five_base = FIVE_W'(k) * SECS_PER_FIVE;
  endfunction

  function automatic logic [MASK_W-1:0] hour_mask(input logic [HOUR_W-1:0] h);
    logic [MASK_W-1:0] m;
    m = '0;
    case (h)
      4'd1:    m[3] = 1'b1;
      4'd2:    m[4] = 1'b1;
      4'd3:    m[5] = 1'b1;
      4'd4:    m[6] = 1'b1;
      4'd5:    m[7] = 1'b1;
      4'd6:    m[8] = 1'b1;
      4'd7:    m[9] = 1'b1;
      4'd8:    m[10] = 1'b1;
      4'd9:    m[11] = 1'b1;
      4'd10:   m[12] = 1'b1;
      4'd11:   m[13] = 1'b1;
      4'd12:   m[W_TWELVE] = 1'b1;
      4'd13:   m[W_TWELVE] = 1'b1;
      default: m = '0;
    endcase
    hour_mask = m;
  endfunction

  function automatic logic [MASK_W-1:0] minute_word(input logic [IDX_W-1:0] k);
    logic [MASK_W-1:0] m;
    m = '0;
    case (k)
      4'd1:    m[W_FIVE] = 1'b1;
      4'd2:    m[W_TEN] = 1'b1;
      4'd3:    begin m[W_TEN] = 1'b1; m[W_TAIL5] = 1'b1; end
      4'd4:    m[W_TWENTY] = 1'b1;
      4'd5:    begin m[W_TWENTY] = 1'b1; m[W_TAIL5] = 1'b1; end
      4'd6:    m[W_THIRTY] = 1'b1;
      4'd7:    begin m[W_THIRTY] = 1'b1; m[W_TAIL5] = 1'b1; end
      4'd8:    m[W_FORTY] = 1'b1;
      4'd9:    begin m[W_FORTY] = 1'b1; m[W_TAIL5] = 1'b1; end
      4'd10:   m[W_FIFTY] = 1'b1;
      4'd11:   begin m[W_FIFTY] = 1'b1; m[W_TAIL5] = 1'b1; end
      default: m = '0;
    endcase
    minute_word = m;
  endfunction

endpackage

[rtl/rtwp_if.sv]
// rtwp_in_if / rtwp_out_if: valid/ready channels for input and result words
// depends on rtwp_pkg

interface rtwp_in_if;
  import rtwp_pkg::*;
  logic                valid;
  logic                ready;
  print_state_t        print_state;
  logic [SECS_W-1:0]   secs_left;
  modport source(output valid, print_state, secs_left, input ready);
  modport sink(input valid, print_state, secs_left, output ready);
endinterface

interface rtwp_out_if;
  import rtwp_pkg::*;
  logic                valid;
  logic                ready;
  logic [MASK_W-1:0]   word_mask;
  logic [BG_W-1:0]     background;
  modport source(output valid, word_mask, background, input ready);
  modport sink(input valid, word_mask, background, output ready);
endinterface

[rtl/rtwp_split.sv]
// rtwp_split: splits remaining seconds into whole hours and leftover seconds
// depends on rtwp_pkg

module rtwp_split (
  input  rtwp_pkg::print_state_t            state,
  input  logic [rtwp_pkg::SECS_W-1:0]       secs,
  output rtwp_pkg::split_t                  split
);
  import rtwp_pkg::*;

  logic [LOW_W-1:0]  low;
  logic [HOUR_W-1:0] h;
  logic              sat;

  assign sat = (secs >= SAT_SECS);
  assign low = secs[LOW_W-1:0];

  always_comb begin
    h = '0;
    for (int k = 1; k <= 12; k++) begin
      if (low >= hour_base(HOUR_W'(k))) h = HOUR_W'(k);
    end
  end

  always_comb begin
    split.state = state;
    split.sat   = sat;
    split.hours = sat ? MAX_HOURS : h;
    split.rem   = sat ? '0 : REM_W'(low - hour_base(h));
  end

endmodule

[rtl/rtwp_words.sv]
// rtwp_words: rounds to five minutes and builds the word mask and background
// depends on rtwp_pkg

module rtwp_words (
  input  rtwp_pkg::split_t              split,
  output logic [rtwp_pkg::MASK_W-1:0]   word_mask,
  output logic [rtwp_pkg::BG_W-1:0]     background
);
  import rtwp_pkg::*;

  logic [FIVE_W-1:0] rounded;
  logic [FIVE_W-1:0] rem_x;
  logic [FIVE_W-1:0] target;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  sidx;
  logic [IDX_W-1:0]  shown_idx;
  logic [HOUR_W-1:0] hw;
  logic              carry;
  logic              zero;
  logic              more;
  logic              less;
  logic [MASK_W-1:0] time_mask;

  assign rem_x   = FIVE_W'(split.rem);
  assign rounded = rem_x + HALF_ROUND;

  always_comb begin
    idx = '0;
    for (int k = 1; k <= 12; k++) begin
      if (rounded >= five_base(IDX_W'(k))) idx = IDX_W'(k);
    end
  end

  always_comb begin
    carry     = (idx == FULL_HOUR_IDX);
    sidx      = (split.sat || carry) ? '0 : idx;
    hw        = split.sat ? MAX_HOURS : split.hours + HOUR_W'(carry);
    zero      = (hw == '0) && (sidx == '0);
    shown_idx = zero ? IDX_W'(1) : sidx;
    target    = five_base(carry ? idx : shown_idx);
    more      = split.sat || (rem_x > target);
    less      = !split.sat && (rem_x < target);
    time_mask = hour_mask(hw) | minute_word(shown_idx);
    time_mask[W_LEFT] = 1'b1;
    time_mask[W_MORE] = more;
    time_mask[W_LESS] = less;
    time_mask[W_THAN] = more || less;
  end

  always_comb begin
    word_mask  = '0;
    background = BG_OFF;
    unique case (split.state) inside
      ST_UNAVAIL: ;
      ST_IDLE:    background = BG_IDLE;
      ST_HEATING: word_mask[W_HEAT] = 1'b1;
      ST_ERROR:   word_mask[W_ERROR] = 1'b1;
      ST_DONE:    word_mask[W_DONE] = 1'b1;
      ST_PAUSED: begin
        word_mask  = time_mask;
        background = BG_PAUSE;
      end
      ST_RESUMING, ST_PRINTING: word_mask = time_mask;
      default: ;
    endcase
  end

endmodule

[rtl/remaining_time_word_phrase.sv]
// remaining_time_word_phrase: top level, three-register pipeline around split and words
// depends on rtwp_pkg, rtwp_if, rtwp_split, rtwp_words
//
// in_chan carries a device state and a remaining time in seconds; out_chan
// returns one word for each input word: a 25-bit mask of lit words and a
// background code. Both channels use valid/ready; a word moves on a rising
// clk edge where both are high.
// The word passes an input register, a register after the hour split, and the
// result register, which drives out_chan.valid. Throughput is one word per
// cycle while out_chan.ready stays high; each stage loads whenever it is
// empty or the stage after it moves, so a new word is taken while a finished
// one still waits on the output.
// When the receiver holds out_chan.ready low the result register holds its
// word and up to two more words wait in the earlier stages before
// in_chan.ready drops.
// rst_n is synchronous and active low; it empties all stages and nothing
// is presented until new words arrive.

module remaining_time_word_phrase (
  input  logic        clk,
  input  logic        rst_n,
  rtwp_in_if.sink     in_chan,
  rtwp_out_if.source  out_chan
);
  import rtwp_pkg::*;

  logic              v0_r, v1_r, v2_r;
  logic              en0, en1, en2;
  print_state_t      state0_r;
  logic [SECS_W-1:0] secs0_r;
  split_t            split_nxt;
  split_t            split1_r;
  logic [MASK_W-1:0] mask_nxt;
  logic [MASK_W-1:0] mask2_r;
  logic [BG_W-1:0]   bg_nxt;
  logic [BG_W-1:0]   bg2_r;

  assign en2 = !v2_r || out_chan.ready;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;

  assign in_chan.ready       = en0;
  assign out_chan.valid      = v2_r;
  assign out_chan.word_mask  = mask2_r;
  assign out_chan.background = bg2_r;

  rtwp_split u_split (
    .state (state0_r),
    .secs  (secs0_r),
    .split (split_nxt)
  );

  rtwp_words u_words (
    .split      (split1_r),
    .word_mask  (mask_nxt),
    .background (bg_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_chan.valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      state0_r <= in_chan.print_state;
      secs0_r  <= in_chan.secs_left;
    end
    if (en1) split1_r <= split_nxt;
    if (en2) begin
      mask2_r <= mask_nxt;
      bg2_r   <= bg_nxt;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> v0_r)
    else $error("accepted word not captured");

  a_than_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.word_mask[W_THAN] ==
      (out_chan.word_mask[W_MORE] || out_chan.word_mask[W_LESS]))
    else $error("than without more or less");

  a_more_less: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !(out_chan.word_mask[W_MORE] && out_chan.word_mask[W_LESS]))
    else $error("more and less both lit");

  a_pause_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.background == BG_PAUSE |-> out_chan.word_mask[W_LEFT])
    else $error("paused without left");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && !out_chan.ready |=> v1_r && $stable(split1_r))
    else $error("middle stage lost a word under stall");

endmodule

[tb/tb_remaining_time_word_phrase.sv]
// tb_remaining_time_word_phrase: self-checking bench for the remaining-time word phrase block
// queue-fed driver, clocked monitor with a built-in phrase predictor, four idle/stall phases
// depends on rtwp_pkg, rtwp_if and rtl/remaining_time_word_phrase.sv

module tb_remaining_time_word_phrase;
  import rtwp_pkg::*;

  localparam int unsigned SECS_HOUR = 3600;
  localparam int unsigned SECS_MIN  = 60;
  localparam int unsigned HOUR_CAP  = 12;
  localparam int unsigned ROUND_MIN = 5;
  localparam int unsigned N_RANDOM  = 1050;
  localparam int unsigned N_PHASES  = 4;
  localparam int unsigned DRAIN_CYC = 8;

  typedef struct {
    print_state_t      st;
    logic [SECS_W-1:0] secs;
  } status_req_t;

  typedef struct {
    logic [MASK_W-1:0] mask;
    bg_t               bg;
  } phrase_t;

  logic clk;
  logic rst_n;

  rtwp_in_if  in_chan ();
  rtwp_out_if out_chan ();

  remaining_time_word_phrase DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  status_req_t status_feed[$];
  phrase_t     pending_phrases[$];
  int unsigned n_total;
  int unsigned n_taken;
  int unsigned n_errors;
  bit          in_moved;

  function automatic phrase_t predict_phrase(print_state_t st, logic [SECS_W-1:0] secs);
    phrase_t     p;
    int unsigned hrs;
    int unsigned mins;
    int unsigned rnd;
    int unsigned shown;
    int unsigned idx;
    p.mask = '0;
    p.bg   = BG_OFF;
    case (st)
      ST_UNAVAIL: p.mask = '0;
      ST_IDLE: p.bg = BG_IDLE;
      ST_HEATING: p.mask[W_HEAT] = 1'b1;
      ST_ERROR: p.mask[W_ERROR] = 1'b1;
      ST_DONE: p.mask[W_DONE] = 1'b1;
      default: begin
        if (st == ST_PAUSED) p.bg = BG_PAUSE;
        hrs  = secs / SECS_HOUR;
        mins = (secs % SECS_HOUR) / SECS_MIN;
        rnd  = ((mins + 2) / ROUND_MIN) * ROUND_MIN;
        if (rnd >= 60) begin
          rnd = 0;
          hrs = hrs + 1;
        end
        // past twelve hours everything shows as exactly twelve
        if (hrs > HOUR_CAP) begin
          hrs = HOUR_CAP;
          rnd = 0;
        end else if (hrs == 0 && rnd == 0) begin
          rnd = ROUND_MIN;
        end
        shown = hrs * SECS_HOUR + rnd * SECS_MIN;
        if (secs > shown) begin
          p.mask[W_MORE] = 1'b1;
          p.mask[W_THAN] = 1'b1;
        end else if (secs < shown) begin
          p.mask[W_LESS] = 1'b1;
          p.mask[W_THAN] = 1'b1;
        end
        // hour words one..eleven sit on bits 3..13, twelve apart
        if (hrs == HOUR_CAP) p.mask[W_TWELVE] = 1'b1;
        else if (hrs >= 1) p.mask[hrs + 2] = 1'b1;
        idx = rnd / ROUND_MIN;
        if (idx == 1) p.mask[W_FIVE] = 1'b1;
        case (idx / 2)
          1: p.mask[W_TEN] = 1'b1;
          2: p.mask[W_TWENTY] = 1'b1;
          3: p.mask[W_THIRTY] = 1'b1;
          4: p.mask[W_FORTY] = 1'b1;
          5: p.mask[W_FIFTY] = 1'b1;
          default: ;
        endcase
        if (idx >= 3 && idx[0]) p.mask[W_TAIL5] = 1'b1;
        p.mask[W_LEFT] = 1'b1;
      end
    endcase
    return p;
  endfunction

  function automatic void queue_req(print_state_t st, logic [SECS_W-1:0] secs);
    status_req_t r;
    r.st   = st;
    r.secs = secs;
    status_feed.push_back(r);
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // driver: inputs and ready change on the falling edge
  always @(negedge clk) begin
    status_req_t r;
    int unsigned phase;
    int unsigned idle_pct;
    int unsigned stall_pct;
    if (!rst_n) begin
      in_chan.valid  <= 1'b0;
      out_chan.ready <= 1'b0;
    end else begin
      phase     = n_taken * N_PHASES / n_total;
      idle_pct  = (phase == 1) ? 76 : (phase == 3) ? 8 : 0;
      stall_pct = (phase == 2) ? 76 : (phase == 3) ? 8 : 0;
      if (in_chan.valid && !in_moved) begin
        // hold the word until it is taken
      end else if (status_feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
        r = status_feed.pop_front();
        in_chan.valid       <= 1'b1;
        in_chan.print_state <= r.st;
        in_chan.secs_left   <= r.secs;
      end else begin
        in_chan.valid <= 1'b0;
      end
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: predicts on input handshakes, checks on output handshakes
  always @(posedge clk) begin
    phrase_t want;
    in_moved = 1'b0;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        pending_phrases.push_back(predict_phrase(in_chan.print_state,
                                                 in_chan.secs_left));
        n_taken  = n_taken + 1;
        in_moved = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (pending_phrases.size() == 0) begin
          $error("unexpected result word: word_mask %h background %0d",
                 out_chan.word_mask, out_chan.background);
          n_errors = n_errors + 1;
        end else begin
          want = pending_phrases.pop_front();
          if (out_chan.word_mask !== want.mask) begin
            $error("word_mask: expected %h, got %h", want.mask, out_chan.word_mask);
            n_errors = n_errors + 1;
          end
          if (out_chan.background !== want.bg) begin
            $error("background: expected %0d, got %0d", want.bg, out_chan.background);
            n_errors = n_errors + 1;
          end
        end
      end
    end
  end

  initial begin
    logic [SECS_W-1:0] secs;
    print_state_t      st;
    int unsigned       pick;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.print_state = ST_UNAVAIL;
    in_chan.secs_left   = '0;
    out_chan.ready      = 1'b0;
    n_taken             = 0;
    n_errors            = 0;
    in_moved            = 1'b0;

    // status states, rounding edges, hour carry, twelve-hour clamp
    queue_req(ST_UNAVAIL, 32'd0);
    queue_req(ST_IDLE, 32'hFFFF_FFFF);
    queue_req(ST_HEATING, 32'd12345);
    queue_req(ST_ERROR, 32'd0);
    queue_req(ST_DONE, 32'hFFFF_FFFF);
    queue_req(ST_PRINTING, 32'd0);
    queue_req(ST_PRINTING, 32'd149);
    queue_req(ST_PRINTING, 32'd150);
    queue_req(ST_PRINTING, 32'd300);
    queue_req(ST_RESUMING, 32'd3570);
    queue_req(ST_PRINTING, 32'd3600);
    queue_req(ST_PRINTING, 32'd7199);
    queue_req(ST_PAUSED, 32'd1979);
    queue_req(ST_PAUSED, 32'd43200);
    queue_req(ST_PRINTING, 32'd43260);
    queue_req(ST_PRINTING, 32'd44400);
    queue_req(ST_PAUSED, 32'd46679);
    queue_req(ST_PRINTING, 32'd46680);
    queue_req(ST_RESUMING, 32'hFFFF_FFFF);
    queue_req(ST_PAUSED, 32'd39000);

    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(9) < 8) st = print_state_t'(3'($urandom_range(5, 7)));
      else st = print_state_t'(3'($urandom_range(0, 7)));
      pick = $urandom_range(9);
      if (pick < 5) secs = $urandom_range(0, 47000);
      else if (pick < 7) secs = $urandom_range(0, 156) * 300 + $urandom_range(0, 1) * 299;
      else if (pick < 8) secs = $urandom_range(0, 3599);
      else secs = $urandom();
      queue_req(st, secs);
    end
    n_total = status_feed.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (n_taken == n_total);
    while (pending_phrases.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_errors == 0) begin
      $display("remaining_time_word_phrase verification clean");
    end else begin
      $display("remaining_time_word_phrase verification failed");
    end
    $finish;
  end

  initial begin
    #3600000;
    $display("remaining_time_word_phrase verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/rtwp_pkg.sv
rtl/rtwp_if.sv
rtl/rtwp_split.sv
rtl/rtwp_words.sv
rtl/remaining_time_word_phrase.sv
tb/tb_remaining_time_word_phrase.sv
